>>> sv/ndcg_pkg.sv
// ============================================================================
// ndcg_pkg
// Shared types, widths and a constant table for the NDCG scoring unit.
// ============================================================================
package ndcg_pkg;

  // List and table sizes
  localparam int MAX_LIST        = 1024;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int FIFO_DEPTH      = 2;

  // Field widths
  localparam int REL_W   = 16;
  localparam int FRAC_W  = 12;
  localparam int EXPO_W  = REL_W - FRAC_W;
  localparam int NDCG_W  = 18;
  localparam int ACC_W   = 40;
  localparam int LEN_W   = 11;

  // Derived widths
  localparam int RANK_W    = $clog2(MAX_LIST);
  localparam int CNT_W     = $clog2(MAX_LIST + 1);
  localparam int N_W       = $clog2(MAX_LIST + 2);
  localparam int P_W       = $clog2(N_W);
  localparam int LOG_FRAC  = 24;
  localparam int LG_W      = P_W + LOG_FRAC;
  localparam int MANT_W    = 31;
  localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int IDX_PRD_W = FRAC_W + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int GAIN_W    = 28;
  localparam int DISC_W    = 16;
  localparam int PROD_W    = GAIN_W + DISC_W;
  localparam int TERM_W    = PROD_W - 14;
  localparam int QCNT_W    = $clog2(NDCG_W + 1);
  localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0] LIST_LEN_MAX = LEN_W'(MAX_LIST);
  localparam logic [NDCG_W-1:0] NDCG_MAX   = '1;

  // Input beat
  typedef struct packed {
    logic [REL_W-1:0] relevance;
    logic [REL_W-1:0] ideal_relevance;
    logic             last;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [NDCG_W-1:0] ndcg;
    logic [ACC_W-1:0]  dcg_sum;
    logic [ACC_W-1:0]  ideal_sum;
    logic              ideal_zero;
    logic              list_overflow;
    logic [LEN_W-1:0]  list_length;
  } out_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [GAIN_W-1:0] gain_rel;
    logic [GAIN_W-1:0] gain_ideal;
    logic [RANK_W-1:0] rank;
    logic              acc;
    logic              last;
  } q_entry_t;

  // Discount unit handshake
  typedef struct packed {
    logic              start;
    logic [RANK_W-1:0] rank;
  } disc_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DISC_W-1:0] disc;
  } disc_rsp_t;

  // exp2 mantissa table, Q1.30, one entry per fraction step
  typedef logic [EXP_TABLE_DEPTH-1:0][MANT_W-1:0] exp_rom_t;

  // floor square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int s = 0; s < 32; s++) begin
      if (b > v) b = b >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // 2^(q/4096) built from the roots 2^(2^-k), evaluated at elaboration
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] roots [1:12];
    logic [63:0] c;
    logic [63:0] m;
    int          q;
    c = 64'd1 << 31;
    for (int k = 1; k <= 12; k++) begin
      c        = isqrt64(c << 30);
      roots[k] = c;
    end
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      q = ((i * 4096) / EXP_TABLE_DEPTH) % 4096;
      m = 64'd1 << 30;
      for (int k = 1; k <= 12; k++) begin
        if (((q >> (12 - k)) & 1) != 0) m = (m * roots[k] + (64'd1 << 29)) >> 30;
      end
      rom[i] = m[MANT_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

>>> sv/ndcg_against_ground_truth_unit.sv
// ============================================================================
// ndcg_against_ground_truth_unit
// Normalized discounted cumulative gain of a ranked list, scored per item.
// ============================================================================
// Per item: an accumulated item is popped and runs the discount unit (24 mantissa
//   squarings, a setup step, a 16-step divide, done), then two multiplies
//   and the last add before the next pop; items past the list limit are dropped.
// Per list: a last item adds the ratio check, an 18-step divide (not for a
//   zero or saturated ratio) and a registered hand-off; a stalled result holds the back end.
// Reset (rst_n low, synchronous): sums, counters, gain_mode and valids clear.
module ndcg_against_ground_truth_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ndcg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ndcg_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  logic                gain_mode_r, gain_mode_nxt;
  logic                q_push, q_pop, q_full, q_empty;
  ndcg_pkg::q_entry_t  q_wr, q_rd;
  ndcg_pkg::disc_req_t disc_req;
  ndcg_pkg::disc_rsp_t disc_rsp;

  // gain mode register
  assign gain_mode_nxt = cfg_wr_en ? cfg_wr_data : gain_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_mode_r <= 1'b0;
    end else begin
      gain_mode_r <= gain_mode_nxt;
    end
  end

  ndcg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .gain_mode (gain_mode_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr)
  );

  ndcg_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  ndcg_disc u_disc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (disc_req),
    .rsp   (disc_rsp)
  );

  ndcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_rd),
    .q_pop     (q_pop),
    .disc_req  (disc_req),
    .disc_rsp  (disc_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // discount unit is never restarted while it works
  a_disc_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    disc_req.start |-> !disc_rsp.busy)
    else $error("discount start while busy");

  // discount never exceeds one in Q1.15
  a_disc_range: assert property (@(posedge clk) disable iff (!rst_n)
    disc_rsp.done |-> (disc_rsp.disc <= ndcg_pkg::DISC_W'(32768)))
    else $error("discount out of range");

  // a zero ideal sum forces a zero ratio
  a_zero_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.ideal_zero) |-> (out_data.ndcg == '0 && out_data.ideal_sum == '0))
    else $error("ideal_zero with nonzero ratio or sum");

  // dropped items only once the list is full
  a_overflow_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.list_overflow) |->
      (out_data.list_length == ndcg_pkg::LIST_LEN_MAX))
    else $error("overflow flagged on a short list");

endmodule

>>> sv/ndcg_fifo.sv
// ============================================================================
// ndcg_fifo
// Short queue of classified items between the front and the back.
// ============================================================================
module ndcg_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ndcg_pkg::q_entry_t wr_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output ndcg_pkg::q_entry_t rd_data
);

  ndcg_pkg::q_entry_t                 mem_r [ndcg_pkg::FIFO_DEPTH];
  logic [ndcg_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ndcg_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ndcg_pkg::FCNT_W-1:0] count_r, count_nxt;

  // status
  assign full    = (count_r == ndcg_pkg::FCNT_W'(ndcg_pkg::FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ndcg_pkg::PTR_W'(ndcg_pkg::FIFO_DEPTH - 1)) ? '0 :
                   wr_ptr_r + ndcg_pkg::PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ndcg_pkg::PTR_W'(ndcg_pkg::FIFO_DEPTH - 1)) ? '0 :
                   rd_ptr_r + ndcg_pkg::PTR_W'(1);
    end
    if (push && !pop) count_nxt = count_r + ndcg_pkg::FCNT_W'(1);
    if (pop && !push) count_nxt = count_r - ndcg_pkg::FCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

>>> sv/ndcg_front.sv
// ============================================================================
// ndcg_front
// Accepts input beats, forms both gains and tags each item with its rank.
// ============================================================================
module ndcg_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ndcg_pkg::in_item_t in_data,
  input  logic               gain_mode,
  input  logic               q_full,
  output logic               q_push,
  output ndcg_pkg::q_entry_t q_entry
);

  logic [ndcg_pkg::CNT_W-1:0] rank_r, rank_nxt;
  logic                       in_range;

  // linear gain, or 2^r - 1 from the mantissa table and an exponent shift
  function automatic logic [ndcg_pkg::GAIN_W-1:0] gain_of(
    input logic [ndcg_pkg::REL_W-1:0] r,
    input logic                       mode
  );
    logic [ndcg_pkg::IDX_PRD_W-1:0] idx_prd;
    logic [ndcg_pkg::EXP_IDX_W-1:0] idx;
    logic [ndcg_pkg::MANT_W-1:0]    m;
    logic [46:0]                    sh;
    logic [28:0]                    v;
    idx_prd = ndcg_pkg::IDX_PRD_W'(r[ndcg_pkg::FRAC_W-1:0]) *
              ndcg_pkg::IDX_PRD_W'(ndcg_pkg::EXP_TABLE_DEPTH);
    idx     = idx_prd[ndcg_pkg::FRAC_W +: ndcg_pkg::EXP_IDX_W];
    m       = ndcg_pkg::EXP_ROM[idx];
    sh      = (47'(m) << r[ndcg_pkg::REL_W-1:ndcg_pkg::FRAC_W]) + (47'd1 << 17);
    v       = sh[46:18];
    if (!mode) return ndcg_pkg::GAIN_W'(r);
    if (v >= 29'd4096) return ndcg_pkg::GAIN_W'(v - 29'd4096);
    return '0;
  endfunction

  // classify and push
  always_comb begin
    in_stall = q_full;
    q_push   = in_valid && !q_full;
    in_range = (rank_r < ndcg_pkg::CNT_W'(ndcg_pkg::MAX_LIST));

    q_entry.gain_rel   = gain_of(in_data.relevance, gain_mode);
    q_entry.gain_ideal = gain_of(in_data.ideal_relevance, gain_mode);
    q_entry.rank       = rank_r[ndcg_pkg::RANK_W-1:0];
    q_entry.acc        = in_range;
    q_entry.last       = in_data.last;

    rank_nxt = rank_r;
    if (q_push) begin
      if (in_data.last)  rank_nxt = '0;
      else if (in_range) rank_nxt = rank_r + ndcg_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
    end else begin
      rank_r <= rank_nxt;
    end
  end

endmodule

>>> sv/ndcg_disc.sv
// ============================================================================
// ndcg_disc
// Iterative discount unit: 1/log2(rank+2) in Q1.15 by squaring then division.
// ============================================================================
module ndcg_disc (
  input  logic                clk,
  input  logic                rst_n,
  input  ndcg_pkg::disc_req_t req,
  output ndcg_pkg::disc_rsp_t rsp
);

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_LOG   = 4'b0010,
    D_SETUP = 4'b0100,
    D_DIV   = 4'b1000
  } dstate_t;

  dstate_t                   state_r, state_nxt;
  logic                      done_r, done_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic [ndcg_pkg::MANT_W-1:0] y_r, y_nxt;
  logic [ndcg_pkg::LG_W-1:0]   lg_r, lg_nxt;
  logic [ndcg_pkg::LG_W-1:0]   rem_r, rem_nxt;
  logic [ndcg_pkg::DISC_W-1:0] dsh_r, dsh_nxt;
  logic [ndcg_pkg::DISC_W-1:0] quo_r, quo_nxt;

  logic [ndcg_pkg::N_W-1:0]  n;
  logic [ndcg_pkg::P_W-1:0]  p;
  logic [61:0]               sq;
  logic [31:0]               t;
  logic [39:0]               dvd;
  logic [ndcg_pkg::LG_W:0]   r2;
  logic                      ge;

  assign rsp.busy = (state_r != D_IDLE);
  assign rsp.done = done_r;
  assign rsp.disc = quo_r;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    y_nxt     = y_r;
    lg_nxt    = lg_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    quo_nxt   = quo_r;

    // integer part of log2 n
    n = ndcg_pkg::N_W'(req.rank) + ndcg_pkg::N_W'(2);
    p = '0;
    for (int b = 0; b < ndcg_pkg::N_W; b++) begin
      if (n[b]) p = ndcg_pkg::P_W'(b);
    end

    // one squaring step of the mantissa
    sq = 62'(y_r) * 62'(y_r);
    t  = sq[61:30];

    // divide 2^39 + lg/2 by lg, remainder seeded with the top bits
    dvd = (40'd1 << 39) + 40'(lg_r >> 1);
    r2  = {rem_r, dsh_r[ndcg_pkg::DISC_W-1]};
    ge  = (r2 >= {1'b0, lg_r});

    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          y_nxt     = ndcg_pkg::MANT_W'(n) << (5'd30 - 5'(p));
          lg_nxt    = ndcg_pkg::LG_W'(p) << ndcg_pkg::LOG_FRAC;
          cnt_nxt   = 5'(ndcg_pkg::LOG_FRAC - 1);
          state_nxt = D_LOG;
        end
      end
      D_LOG: begin
        if (t[31]) begin
          y_nxt  = t[31:1];
          lg_nxt = lg_r | (ndcg_pkg::LG_W'(1) << cnt_r);
        end else begin
          y_nxt  = t[30:0];
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) state_nxt = D_SETUP;
      end
      D_SETUP: begin
        rem_nxt   = ndcg_pkg::LG_W'(dvd[39:ndcg_pkg::DISC_W]);
        dsh_nxt   = dvd[ndcg_pkg::DISC_W-1:0];
        cnt_nxt   = 5'(ndcg_pkg::DISC_W - 1);
        state_nxt = D_DIV;
      end
      D_DIV: begin
        rem_nxt = ge ? ndcg_pkg::LG_W'(r2 - {1'b0, lg_r}) : r2[ndcg_pkg::LG_W-1:0];
        quo_nxt = {quo_r[ndcg_pkg::DISC_W-2:0], ge};
        dsh_nxt = dsh_r << 1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    y_r   <= y_nxt;
    lg_r  <= lg_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

endmodule

>>> sv/ndcg_back.sv
// ============================================================================
// ndcg_back
// Weights gains by the discount, keeps both sums and closes each list with
// the ratio (bit-serial divide, or zero/saturated) into a result register.
// ============================================================================
module ndcg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ndcg_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output ndcg_pkg::disc_req_t disc_req,
  input  ndcg_pkg::disc_rsp_t disc_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output ndcg_pkg::out_item_t out_data
);

  typedef enum logic [7:0] {
    B_IDLE = 8'b0000_0001,
    B_DISC = 8'b0000_0010,
    B_MULD = 8'b0000_0100,
    B_MULI = 8'b0000_1000,
    B_ADDI = 8'b0001_0000,
    B_FIN  = 8'b0010_0000,
    B_DIV  = 8'b0100_0000,
    B_OUT  = 8'b1000_0000
  } bstate_t;

  bstate_t state_r, state_nxt;

  // list state
  logic [ndcg_pkg::ACC_W-1:0] dcg_r, dcg_nxt;
  logic [ndcg_pkg::ACC_W-1:0] ideal_r, ideal_nxt;
  logic [ndcg_pkg::CNT_W-1:0] len_r, len_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // working registers
  ndcg_pkg::q_entry_t          ent_r, ent_nxt;
  logic [ndcg_pkg::DISC_W-1:0] disc_r, disc_nxt;
  logic [ndcg_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [ndcg_pkg::ACC_W-1:0]  rem_r, rem_nxt;
  logic [ndcg_pkg::NDCG_W-1:0] nsh_r, nsh_nxt;
  logic [ndcg_pkg::NDCG_W-1:0] quo_r, quo_nxt;
  logic [ndcg_pkg::QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic                        zero_r, zero_nxt;
  ndcg_pkg::out_item_t         out_r, out_nxt;

  logic [ndcg_pkg::PROD_W:0]   tsum;
  logic [ndcg_pkg::TERM_W-1:0] term;
  logic [ndcg_pkg::ACC_W:0]    asum;
  logic [56:0]                 num;
  logic [57:0]                 lim;
  logic [ndcg_pkg::ACC_W:0]    r2;
  logic                        ge;
  logic                        out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    dcg_nxt       = dcg_r;
    ideal_nxt     = ideal_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    ent_nxt       = ent_r;
    disc_nxt      = disc_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    nsh_nxt       = nsh_r;
    quo_nxt       = quo_r;
    qcnt_nxt      = qcnt_r;
    zero_nxt      = zero_r;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    disc_req.start = 1'b0;
    disc_req.rank  = q_head.rank;

    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;

    // rounded Q.12 term from the registered product, then saturating add
    tsum = (ndcg_pkg::PROD_W + 1)'(prod_r) + ((ndcg_pkg::PROD_W + 1)'(1) << 14);
    term = tsum[ndcg_pkg::PROD_W:15];
    asum = (ndcg_pkg::ACC_W + 1)'(state_r == B_MULI ? dcg_r : ideal_r) +
           (ndcg_pkg::ACC_W + 1)'(term);

    // rounded numerator and saturation limit of the ratio
    num = {1'b0, dcg_r, 16'b0} + 57'(ideal_r >> 1);
    lim = {ideal_r, 18'b0};

    // one quotient bit per cycle
    r2 = {rem_r, nsh_r[ndcg_pkg::NDCG_W-1]};
    ge = (r2 >= {1'b0, ideal_r});

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_head;
          if (q_head.acc) begin
            disc_req.start = 1'b1;
            state_nxt      = B_DISC;
          end else begin
            ovf_nxt   = 1'b1;
            state_nxt = q_head.last ? B_FIN : B_IDLE;
          end
        end
      end
      B_DISC: begin
        if (disc_rsp.done) begin
          disc_nxt  = disc_rsp.disc;
          state_nxt = B_MULD;
        end
      end
      B_MULD: begin
        prod_nxt  = ndcg_pkg::PROD_W'(ent_r.gain_rel) * ndcg_pkg::PROD_W'(disc_r);
        state_nxt = B_MULI;
      end
      B_MULI: begin
        dcg_nxt   = asum[ndcg_pkg::ACC_W] ? '1 : asum[ndcg_pkg::ACC_W-1:0];
        prod_nxt  = ndcg_pkg::PROD_W'(ent_r.gain_ideal) * ndcg_pkg::PROD_W'(disc_r);
        state_nxt = B_ADDI;
      end
      B_ADDI: begin
        ideal_nxt = asum[ndcg_pkg::ACC_W] ? '1 : asum[ndcg_pkg::ACC_W-1:0];
        len_nxt   = len_r + ndcg_pkg::CNT_W'(1);
        state_nxt = ent_r.last ? B_FIN : B_IDLE;
      end
      B_FIN: begin
        zero_nxt = (ideal_r == '0);
        if (ideal_r == '0) begin
          quo_nxt   = '0;
          state_nxt = B_OUT;
        end else if ({1'b0, num} >= lim) begin
          quo_nxt   = ndcg_pkg::NDCG_MAX;
          state_nxt = B_OUT;
        end else begin
          rem_nxt   = ndcg_pkg::ACC_W'(num[56:ndcg_pkg::NDCG_W]);
          nsh_nxt   = num[ndcg_pkg::NDCG_W-1:0];
          qcnt_nxt  = ndcg_pkg::QCNT_W'(ndcg_pkg::NDCG_W - 1);
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        rem_nxt  = ge ? ndcg_pkg::ACC_W'(r2 - {1'b0, ideal_r}) : r2[ndcg_pkg::ACC_W-1:0];
        quo_nxt  = {quo_r[ndcg_pkg::NDCG_W-2:0], ge};
        nsh_nxt  = nsh_r << 1;
        qcnt_nxt = qcnt_r - ndcg_pkg::QCNT_W'(1);
        if (qcnt_r == '0) state_nxt = B_OUT;
      end
      B_OUT: begin
        // hand the result to the output register, then clear for next list
        if (out_free) begin
          out_nxt.ndcg          = quo_r;
          out_nxt.dcg_sum       = dcg_r;
          out_nxt.ideal_sum     = ideal_r;
          out_nxt.ideal_zero    = zero_r;
          out_nxt.list_overflow = ovf_r;
          out_nxt.list_length   = ndcg_pkg::LEN_W'(len_r);
          out_valid_nxt         = 1'b1;
          dcg_nxt               = '0;
          ideal_nxt             = '0;
          len_nxt               = '0;
          ovf_nxt               = 1'b0;
          state_nxt             = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      dcg_r       <= '0;
      ideal_r     <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dcg_r       <= dcg_nxt;
      ideal_r     <= ideal_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    disc_r <= disc_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    nsh_r  <= nsh_nxt;
    quo_r  <= quo_nxt;
    qcnt_r <= qcnt_nxt;
    zero_r <= zero_nxt;
    out_r  <= out_nxt;
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the NDCG scoring unit: directed probe rows, then
// random ranked lists scored against an in-bench model of the discount, gain
// and ratio arithmetic, with bursty input and a patterned output stall.
// ============================================================================
module tb;
  import ndcg_pkg::*;

  localparam int DRAIN_CYCLES = 250;   // queued items plus ratio divide
  localparam int IDLE_LIMIT   = 4000;  // cycles without any beat
  localparam int RAND_ITEMS   = 2000;
  localparam logic [63:0] SUM_LIMIT = (64'd1 << ACC_W) - 1;
  localparam logic [63:0] RATIO_CAP = 64'd262143;

  typedef struct {
    bit        mode;
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } probe_row_t;

  logic      clk;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;

  // model state
  bit          gain_mode_q;
  int unsigned rank_pos;
  logic [63:0] dcg_run;
  logic [63:0] ideal_run;
  bit          dropped_seen;
  logic [63:0] root2_tab [1:12];

  out_item_t   expected_scores [$];
  probe_row_t  probe_rows [$];
  int          mismatch_count;
  int          burst_left;
  int          idle_cycles;
  logic [1:0]  stall_style;
  logic [15:0] stall_cyc;

  ndcg_against_ground_truth_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model arithmetic
  // ---------------------------------------------------------------------------

  // floor square root, digit by digit from the top
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // 1/log2(n) in Q1.15, log2 formed by repeated squaring of the mantissa
  function automatic logic [63:0] rank_discount(int unsigned n);
    int          p;
    logic [63:0] y;
    logic [63:0] lg;
    p = 0;
    while ((n >> (p + 1)) != 0) p++;
    y  = 64'(n) << (30 - p);
    lg = 64'(p) << 24;
    for (int k = 23; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y     = y >> 1;
        lg[k] = 1'b1;
      end
    end
    return ((64'd1 << 39) + lg / 2) / lg;
  endfunction

  // linear r, or 2^r - 1 from the quantized exp2 table, in Q.12
  function automatic logic [63:0] relevance_gain(logic [15:0] r, bit m);
    int unsigned e;
    int unsigned idx;
    int unsigned q;
    logic [63:0] mant;
    logic [63:0] v;
    if (!m) return 64'(r);
    e    = r[15:12];
    idx  = (int'(r[11:0]) * EXP_TABLE_DEPTH) >> 12;
    q    = ((idx * 4096) / EXP_TABLE_DEPTH) % 4096;
    mant = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      if (((q >> (12 - k)) & 1) != 0) mant = (mant * root2_tab[k] + (64'd1 << 29)) >> 30;
    end
    v = ((mant << e) + (64'd1 << 17)) >> 18;
    return (v >= 64'd4096) ? v - 64'd4096 : 64'd0;
  endfunction

  function automatic logic [63:0] sum_sat(logic [63:0] acc, logic [63:0] term);
    logic [63:0] s;
    s = acc + term;
    return (s > SUM_LIMIT) ? SUM_LIMIT : s;
  endfunction

  // advance the list state by one beat; returns 1 with the score on last
  function automatic bit ndcg_step(input in_item_t b, output out_item_t res);
    logic [63:0] disc;
    logic [63:0] ratio;
    res = '0;
    if (rank_pos < MAX_LIST) begin
      disc      = rank_discount(rank_pos + 2);
      dcg_run   = sum_sat(dcg_run,
                          (relevance_gain(b.relevance, gain_mode_q) * disc + (64'd1 << 14)) >> 15);
      ideal_run = sum_sat(ideal_run,
                          (relevance_gain(b.ideal_relevance, gain_mode_q) * disc
                           + (64'd1 << 14)) >> 15);
      rank_pos++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!b.last) return 1'b0;
    if (ideal_run == 0) begin
      ratio          = '0;
      res.ideal_zero = 1'b1;
    end else begin
      ratio = ((dcg_run << 16) + ideal_run / 2) / ideal_run;
      if (ratio > RATIO_CAP) ratio = RATIO_CAP;
    end
    res.ndcg          = ratio[NDCG_W-1:0];
    res.dcg_sum       = dcg_run[ACC_W-1:0];
    res.ideal_sum     = ideal_run[ACC_W-1:0];
    res.list_overflow = dropped_seen;
    res.list_length   = rank_pos[LEN_W-1:0];
    rank_pos     = 0;
    dcg_run      = '0;
    ideal_run    = '0;
    dropped_seen = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // drive one beat in bursts with random gaps; score it once accepted
  task automatic push_beat(in_item_t b, bit typed, out_item_t want);
    int        gap;
    out_item_t score;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (ndcg_step(b, score)) expected_scores = {expected_scores, (typed ? want : score)};
  endtask

  // stop sending, let every score come back and the back end go quiet
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    gain_mode_q = m;
  endtask

  task automatic add_row(bit mode, logic [15:0] rel, logic [15:0] ide, bit last, bit typed,
                         logic [NDCG_W-1:0] ndcg, logic [ACC_W-1:0] dcg,
                         logic [ACC_W-1:0] ideal, bit zero, logic [LEN_W-1:0] len);
    probe_row_t row;
    row.mode                 = mode;
    row.beat.relevance       = rel;
    row.beat.ideal_relevance = ide;
    row.beat.last            = last;
    row.typed                = typed;
    row.want.ndcg            = ndcg;
    row.want.dcg_sum         = dcg;
    row.want.ideal_sum       = ideal;
    row.want.ideal_zero      = zero;
    row.want.list_overflow   = 1'b0;
    row.want.list_length     = len;
    probe_rows = {probe_rows, row};
  endtask

  function automatic logic [15:0] pick_relevance();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 4095));
      3:       return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_scores.size() == 0) begin
        report_mismatch("score beat with nothing pending");
      end else begin
        want = expected_scores.pop_front();
        if (out_data.ndcg !== want.ndcg)
          report_mismatch($sformatf("ndcg got %0d want %0d", out_data.ndcg, want.ndcg));
        if (out_data.dcg_sum !== want.dcg_sum)
          report_mismatch($sformatf("dcg_sum got %0d want %0d",
                                    out_data.dcg_sum, want.dcg_sum));
        if (out_data.ideal_sum !== want.ideal_sum)
          report_mismatch($sformatf("ideal_sum got %0d want %0d",
                                    out_data.ideal_sum, want.ideal_sum));
        if (out_data.ideal_zero !== want.ideal_zero)
          report_mismatch($sformatf("ideal_zero got %0b want %0b",
                                    out_data.ideal_zero, want.ideal_zero));
        if (out_data.list_overflow !== want.list_overflow)
          report_mismatch($sformatf("list_overflow got %0b want %0b",
                                    out_data.list_overflow, want.list_overflow));
        if (out_data.list_length !== want.list_length)
          report_mismatch($sformatf("list_length got %0d want %0d",
                                    out_data.list_length, want.list_length));
      end
    end
  end

  // Output stall: a randomly redrawn style, including no-stall stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_style <= '0;
      stall_cyc   <= '0;
    end else begin
      stall_cyc <= stall_cyc + 16'd1;
      if (stall_cyc[8:0] == 9'd0) stall_style <= 2'($urandom_range(0, 3));
      case (stall_style)
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 99) < 30);
        2'd2:    out_stall <= ($urandom_range(0, 99) < 80);
        default: out_stall <= (stall_cyc[3:0] < 4'd11);
      endcase
    end
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t b;
    int       rand_items;
    int       list_no;
    int       len;
    int       ideal_style;
    logic [63:0] c;

    mismatch_count = 0;
    burst_left     = 0;
    idle_cycles    = 0;
    gain_mode_q    = 1'b0;
    rank_pos       = 0;
    dcg_run        = '0;
    ideal_run      = '0;
    dropped_seen   = 1'b0;

    // roots 2^(2^-k) in Q1.30 for the exp2 table
    c = 64'd1 << 31;
    for (int k = 1; k <= 12; k++) begin
      c            = floor_root(c << 30);
      root2_tab[k] = c;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: zero list, unit gain at rank 1, saturated ratio, exp mode
    add_row(1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1, 18'd0, 40'd0, 40'd0, 1'b1, 11'd1);
    add_row(1'b0, 16'h1000, 16'h1000, 1'b1, 1'b1, 18'd65536, 40'd4096, 40'd4096, 1'b0, 11'd1);
    add_row(1'b0, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 18'd0, 40'd65535, 40'd0, 1'b1, 11'd1);
    add_row(1'b0, 16'hFFFF, 16'h0001, 1'b1, 1'b1, 18'd262143, 40'd65535, 40'd1, 1'b0, 11'd1);
    add_row(1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b0, 16'h5555, 16'hAAAA, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b1, 16'h0000, 16'h1000, 1'b1, 1'b1, 18'd0, 40'd0, 40'd4096, 1'b0, 11'd1);
    add_row(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b1, 16'h0FFF, 16'hF000, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b1, 16'h0010, 16'h000F, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b1, 16'hAAAA, 16'h5555, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b1, 16'h7FFF, 16'h8001, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);
    // gain mode switched in the middle of a list
    add_row(1'b1, 16'h3000, 16'h2000, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b1, 16'h1234, 16'h4321, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b0, 16'h3000, 16'h2000, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b0, 16'hEDCB, 16'h1357, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);
    add_row(1'b1, 16'h4000, 16'h0800, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0);

    foreach (probe_rows[i]) begin
      if (probe_rows[i].mode != gain_mode_q) begin
        settle();
        write_mode(probe_rows[i].mode);
      end
      push_beat(probe_rows[i].beat, probe_rows[i].typed, probe_rows[i].want);
    end
    settle();

    // random lists; one long list runs past the list limit and ends on a drop
    rand_items = 0;
    list_no    = 0;
    while (rand_items < RAND_ITEMS) begin
      list_no++;
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_mode(1'($urandom_range(0, 1)));
      end
      if (list_no == 40) len = MAX_LIST + 3;
      else if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 8);
      else len = $urandom_range(9, 80);
      ideal_style = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        if (i == len / 2 && len > 2 && $urandom_range(0, 15) == 0) begin
          settle();
          write_mode(!gain_mode_q);
        end
        b.relevance = pick_relevance();
        case (ideal_style)
          0:       b.ideal_relevance = 16'h0000;
          1:       b.ideal_relevance = 16'($urandom_range(0, 15));
          default: b.ideal_relevance = pick_relevance();
        endcase
        b.last = (i == len - 1);
        push_beat(b, 1'b0, '0);
        rand_items++;
      end
    end
    settle();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
